/* rtl/cdn_pkg.sv */
// Shared types, constants and calendar tables for the day-number unit.
`default_nettype none

package cdn_pkg;

  localparam int FIRST_YEAR   = 1582;
  localparam int DEF_MAX_YEAR = 9999;
  localparam int LEAPS_BEFORE = 383;

  localparam int DW  = 5;
  localparam int MW  = 4;
  localparam int YW  = 14;
  localparam int CW  = 22;
  localparam int YIW = 15;
  localparam int QW  = 9;
  localparam int RW  = 9;
  localparam int SW  = 24;
  localparam int NW  = 25;

  localparam int S_TDATA_W = 72;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 48;
  localparam int M_TUSER_W = 2;

  localparam logic [12:0] RECIP100    = 13'd5243;
  localparam int          RECIP100_SH = 19;
  localparam logic [23:0] RECIP_YEAR    = 24'd11759221;
  localparam int          RECIP_YEAR_SH = 32;

  typedef enum logic [2:0] {
    ACT_TO_DAYS   = 3'd0,
    ACT_TO_DATE   = 3'd1,
    ACT_ADD_DAYS  = 3'd2,
    ACT_SUB_DAYS  = 3'd3,
    ACT_ADD_DATES = 3'd4,
    ACT_SUB_DATES = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_OVER = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_MULY, S_MULYM1, S_JDAY, S_SERA, S_SERB, S_FORMN,
    S_RANGE, S_GMUL, S_GSET, S_CHECK, S_MONTH, S_WRITE
  } state_t;

  typedef enum logic [1:0] {
    PH_A, PH_B, PH_FIND
  } phase_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MULY, OP_MULYM1, OP_JDAY, OP_SERA, OP_SERB, OP_FORMN,
    OP_GMUL, OP_GSET, OP_DEC, OP_INC, OP_REM, OP_MSTEP, OP_WRITE
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t code;
  } cmd_t;

  typedef struct packed {
    logic is_days;
    logic is_pair;
    logic act_bad;
    logic bad_a;
    logic bad_b;
    logic n_low;
    logic n_high;
    logic j_over;
    logic j_under;
    logic m_more;
    logic out_busy;
  } stat_t;

  function automatic logic [DW-1:0] month_len(input logic [MW-1:0] m, input logic leap);
    logic [DW-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [RW-1:0] cum_days(input logic [MW-1:0] m);
    logic [RW-1:0] c;
    unique case (m)
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/cdn_ctrl.sv */
// Sequencer for the day-number unit: steps the datapath through one item.
`default_nettype none

module cdn_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  cdn_pkg::stat_t stat,
  output cdn_pkg::cmd_t  cmd
);
  import cdn_pkg::*;

  state_t  state, state_next;
  phase_t  phase, phase_next;
  status_t code, code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_A;
      code  <= ST_OK;
    end else begin
      state <= state_next;
      phase <= phase_next;
      code  <= code_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    code_next  = code;
    cmd.op     = OP_NONE;
    cmd.code   = code;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op     = OP_LOAD;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (stat.is_days) begin
          state_next = S_FORMN;
        end else begin
          phase_next = PH_A;
          state_next = S_MULY;
        end
      end
      S_MULY: begin
        cmd.op     = OP_MULY;
        state_next = S_MULYM1;
      end
      S_MULYM1: begin
        cmd.op     = OP_MULYM1;
        state_next = S_JDAY;
      end
      S_JDAY: begin
        cmd.op = OP_JDAY;
        unique case (phase)
          PH_A:    state_next = S_SERA;
          PH_B:    state_next = S_SERB;
          default: state_next = S_CHECK;
        endcase
      end
      S_SERA: begin
        if (stat.act_bad || stat.bad_a) begin
          code_next  = ST_BAD;
          state_next = S_WRITE;
        end else begin
          cmd.op = OP_SERA;
          if (stat.is_pair) begin
            phase_next = PH_B;
            state_next = S_MULY;
          end else begin
            state_next = S_FORMN;
          end
        end
      end
      S_SERB: begin
        if (stat.bad_b) begin
          code_next  = ST_BAD;
          state_next = S_WRITE;
        end else begin
          cmd.op     = OP_SERB;
          state_next = S_RANGE;
        end
      end
      S_FORMN: begin
        cmd.op     = OP_FORMN;
        state_next = S_RANGE;
      end
      S_RANGE: begin
        priority if (stat.n_low) begin
          code_next  = ST_BAD;
          state_next = S_WRITE;
        end else if (stat.n_high) begin
          code_next  = ST_OVER;
          state_next = S_WRITE;
        end else begin
          state_next = S_GMUL;
        end
      end
      S_GMUL: begin
        cmd.op     = OP_GMUL;
        state_next = S_GSET;
      end
      S_GSET: begin
        cmd.op     = OP_GSET;
        phase_next = PH_FIND;
        state_next = S_MULY;
      end
      S_CHECK: begin
        priority if (stat.j_over) begin
          cmd.op     = OP_DEC;
          state_next = S_MULY;
        end else if (stat.j_under) begin
          cmd.op     = OP_INC;
          state_next = S_MULY;
        end else begin
          cmd.op     = OP_REM;
          state_next = S_MONTH;
        end
      end
      S_MONTH: begin
        if (stat.m_more) begin
          cmd.op = OP_MSTEP;
        end else begin
          code_next  = ST_OK;
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        if (!stat.out_busy) begin
          cmd.op     = OP_WRITE;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/cdn_dpath.sv */
// Datapath of the day-number unit: operand registers, year arithmetic, result register.
`default_nettype none

module cdn_dpath #(
  parameter int MAX_YEAR = cdn_pkg::DEF_MAX_YEAR
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cdn_pkg::cmd_t           cmd,
  output cdn_pkg::stat_t          stat,
  input  logic [2:0]              action,
  input  logic [cdn_pkg::DW-1:0]  day_a,
  input  logic [cdn_pkg::MW-1:0]  month_a,
  input  logic [cdn_pkg::YW-1:0]  year_a,
  input  logic [cdn_pkg::DW-1:0]  day_b,
  input  logic [cdn_pkg::MW-1:0]  month_b,
  input  logic [cdn_pkg::YW-1:0]  year_b,
  input  logic [cdn_pkg::CW-1:0]  day_count,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [cdn_pkg::DW-1:0]  res_day,
  output logic [cdn_pkg::MW-1:0]  res_month,
  output logic [cdn_pkg::YW-1:0]  res_year,
  output logic [cdn_pkg::CW-1:0]  res_serial,
  output cdn_pkg::status_t        status
);
  import cdn_pkg::*;

  localparam int MAX_SERIAL = 365 * (MAX_YEAR + 1 - FIRST_YEAR) + MAX_YEAR / 4
                            - MAX_YEAR / 100 + MAX_YEAR / 400 - LEAPS_BEFORE;

  logic [2:0]            act;
  logic [DW-1:0]         da, db;
  logic [MW-1:0]         ma, mb, mm;
  logic [YW-1:0]         ya, yb;
  logic [CW-1:0]         cnt;
  logic [YIW-1:0]        yy, gp;
  logic [QW-1:0]         q_y, q_ym1;
  logic [SW-1:0]         jd;
  logic signed [NW-1:0]  sa, nn;
  logic [RW-1:0]         rem;

  logic [YIW-1:0]        ym1, yoff, mul_in;
  logic [YIW+12:0]       qprod;
  logic [2*SW-1:0]       gprod;
  logic                  leap;
  logic [RW-1:0]         ylen, mlen;
  logic [SW-1:0]         d0, ser_a, ser_b;
  logic signed [NW-1:0]  ser_b_s, cnt_s;

  assign ym1    = yy - YIW'(1);
  assign yoff   = yy - YIW'(FIRST_YEAR);
  assign mul_in = (cmd.op == OP_MULYM1) ? ym1 : yy;
  assign qprod  = mul_in * RECIP100;
  assign leap   = (yy[1:0] == 2'b00) && ((q_y != q_ym1) ? (q_y[1:0] == 2'b00) : 1'b1);
  assign ylen   = RW'(365) + RW'(leap);
  assign mlen   = RW'(month_len(mm, leap));
  assign d0     = nn[SW-1:0] - SW'(1);
  assign gprod  = (2*SW)'(d0) * (2*SW)'(RECIP_YEAR);

  assign ser_a   = jd + SW'(cum_days(ma)) + SW'(leap && (ma > 4'd2)) + SW'(da);
  assign ser_b   = jd + SW'(cum_days(mb)) + SW'(leap && (mb > 4'd2)) + SW'(db);
  assign ser_b_s = $signed({1'b0, ser_b});
  assign cnt_s   = $signed(NW'(cnt));

  assign stat.is_days  = (act == ACT_TO_DATE);
  assign stat.is_pair  = (act == ACT_ADD_DATES) || (act == ACT_SUB_DATES);
  assign stat.act_bad  = (act > ACT_SUB_DATES);
  assign stat.bad_a    = (ya < YW'(FIRST_YEAR)) || (ya > YW'(MAX_YEAR)) || (da == '0)
                         || (da > month_len(ma, leap));
  assign stat.bad_b    = (yb < YW'(FIRST_YEAR)) || (yb > YW'(MAX_YEAR)) || (db == '0)
                         || (db > month_len(mb, leap));
  assign stat.n_low    = nn[NW-1] || (nn == '0);
  assign stat.n_high   = nn > $signed(NW'(MAX_SERIAL));
  assign stat.j_over   = jd > d0;
  assign stat.j_under  = ({1'b0, jd} + (SW+1)'(ylen)) <= {1'b0, d0};
  assign stat.m_more   = rem >= mlen;
  assign stat.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        act <= action;
        da  <= day_a;
        ma  <= month_a;
        ya  <= year_a;
        db  <= day_b;
        mb  <= month_b;
        yb  <= year_b;
        cnt <= day_count;
        yy  <= YIW'(year_a);
      end
      OP_MULY:   q_y   <= qprod[RECIP100_SH +: QW];
      OP_MULYM1: q_ym1 <= qprod[RECIP100_SH +: QW];
      OP_JDAY: begin
        jd <= SW'(yoff) * SW'(365) + SW'(ym1 >> 2) - SW'(q_ym1) + SW'(q_ym1 >> 2)
              - SW'(LEAPS_BEFORE);
      end
      OP_SERA: begin
        sa <= $signed({1'b0, ser_a});
        yy <= YIW'(yb);
      end
      OP_SERB: nn <= (act == ACT_ADD_DATES) ? sa + ser_b_s : sa - ser_b_s;
      OP_FORMN: begin
        unique case (act)
          ACT_TO_DATE:  nn <= cnt_s;
          ACT_ADD_DAYS: nn <= sa + cnt_s;
          ACT_SUB_DAYS: nn <= sa - cnt_s;
          default:      nn <= sa;
        endcase
      end
      OP_GMUL: gp <= gprod[RECIP_YEAR_SH +: YIW];
      OP_GSET: yy <= YIW'(FIRST_YEAR) + gp;
      OP_DEC:  yy <= yy - YIW'(1);
      OP_INC:  yy <= yy + YIW'(1);
      OP_REM: begin
        rem <= RW'(d0 - jd);
        mm  <= MW'(1);
      end
      OP_MSTEP: begin
        rem <= rem - mlen;
        mm  <= mm + MW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_WRITE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE) begin
      status <= cmd.code;
      if (cmd.code == ST_OK) begin
        res_day    <= DW'(rem + RW'(1));
        res_month  <= mm;
        res_year   <= yy[YW-1:0];
        res_serial <= nn[CW-1:0];
      end else begin
        res_day    <= '0;
        res_month  <= '0;
        res_year   <= '0;
        res_serial <= '0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_WRITE) |-> !(out_valid && !out_ready))
    else $error("result register overwritten while held");

  a_ok_date: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OK) |-> (res_day != '0 && res_month != '0 && res_month <= 4'd12))
    else $error("ok result without a proper date");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK)
      |-> (res_day == '0 && res_month == '0 && res_year == '0 && res_serial == '0))
    else $error("error result carries data");

  a_month_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_MSTEP) |-> (mm < 4'd12))
    else $error("month step past December");

endmodule

`default_nettype wire

/* rtl/calendar_day_number_arithmetic.sv */
// Top level of the Gregorian day-number unit: stream ports, sequencer and datapath.
`default_nettype none

// Converts Gregorian dates (1 January 1582 is day 1) to day numbers and back, adds or
// subtracts day counts, or adds or subtracts two dates' day numbers. One result item per
// input item. An item holds the unit from its accept cycle until its result is written,
// and the write waits while the previous result still waits at the output. Each date
// costs a pass through the shared leap-count multiplier. The year of the result comes
// from a reciprocal estimate that is at most one year off, checked by one or two such
// passes. The month is found by stepping one month per cycle. A bad date or an
// out-of-range day number ends the item early. Status 1 flags a bad date, unused
// action or day number below one; status 2 flags a result past 31 December MAX_YEAR;
// error results carry zeros.
// The next item is taken while a finished result waits in the output register.
module calendar_day_number_arithmetic #(
  parameter int MAX_YEAR = cdn_pkg::DEF_MAX_YEAR
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // day_a, month_a, year_a, day_b, month_b, year_b, day_count
  input  logic [cdn_pkg::S_TDATA_W-1:0]   s_tdata,
  // action
  input  logic [cdn_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // res_day, res_month, res_year, res_serial
  output logic [cdn_pkg::M_TDATA_W-1:0]   m_tdata,
  // status
  output logic [cdn_pkg::M_TUSER_W-1:0]   m_tuser
);
  import cdn_pkg::*;

  cmd_t          cmd;
  stat_t         stat;
  logic [DW-1:0] res_day;
  logic [MW-1:0] res_month;
  logic [YW-1:0] res_year;
  logic [CW-1:0] res_serial;
  status_t       status;

  cdn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cdn_dpath #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .action     (s_tuser),
    .day_a      (s_tdata[4:0]),
    .month_a    (s_tdata[8:5]),
    .year_a     (s_tdata[22:9]),
    .day_b      (s_tdata[27:23]),
    .month_b    (s_tdata[31:28]),
    .year_b     (s_tdata[45:32]),
    .day_count  (s_tdata[67:46]),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .res_day    (res_day),
    .res_month  (res_month),
    .res_year   (res_year),
    .res_serial (res_serial),
    .status     (status)
  );

  assign m_tdata = {3'b000, res_serial, res_year, res_month, res_day};
  assign m_tuser = status;

endmodule

`default_nettype wire
